### src/rd64_pkg.sv
// Shared types and constants for the pipelined restoring divider.
`default_nettype none

package rd64_pkg;

  // Fixed width of the dividend, divisor and quotient fields on the ports.
  localparam int FIELD_W = 64;

  // Division kinds carried on in_tuser.
  localparam logic KIND_UNSIGNED = 1'b0;
  localparam logic KIND_SIGNED   = 1'b1;

  // Per-beat control that travels alongside the data through every stage.
  typedef struct packed {
    logic vld;   // stage holds a live beat
    logic flip;  // negate the quotient at the end
    logic dbz;   // divisor was zero
  } rd_ctl_t;

endpackage : rd64_pkg

`default_nettype wire

### src/rd64_prep.sv
// Input stage: sign handling, magnitudes and zero-divisor detect.
`default_nettype none

module rd64_prep
  import rd64_pkg::*;
#(
  parameter int W = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         adv,
  input  wire logic         in_vld,
  input  wire logic         kind,
  input  wire logic [W-1:0] num,
  input  wire logic [W-1:0] den,
  output rd_ctl_t           ctl_r,
  output logic      [W-1:0] num_r,
  output logic      [W-1:0] den_r
);

  logic         num_neg;
  logic         den_neg;
  rd_ctl_t      ctl_nxt;
  logic [W-1:0] num_nxt;
  logic [W-1:0] den_nxt;

  always_comb begin
    num_neg      = (kind == KIND_SIGNED) && num[W-1];
    den_neg      = (kind == KIND_SIGNED) && den[W-1];
    // most negative value negates to itself, read as unsigned 2^(W-1)
    num_nxt      = num_neg ? (~num + W'(1)) : num;
    den_nxt      = den_neg ? (~den + W'(1)) : den;
    ctl_nxt.vld  = in_vld;
    ctl_nxt.flip = num_neg ^ den_neg;
    ctl_nxt.dbz  = (den == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_r <= num_nxt;
      den_r <= den_nxt;
    end
  end

endmodule : rd64_prep

`default_nettype wire

### src/rd64_stage.sv
// One restoring step: shift in a dividend bit, trial subtract, one quotient bit.
`default_nettype none

module rd64_stage
  import rd64_pkg::*;
#(
  parameter int W = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         adv,
  input  wire rd_ctl_t      ctl,
  input  wire logic [W-1:0] rem,
  input  wire logic [W-1:0] nq,   // dividend bits not yet used, quotient bits below
  input  wire logic [W-1:0] den,
  output rd_ctl_t           ctl_r,
  output logic      [W-1:0] rem_r,
  output logic      [W-1:0] nq_r,
  output logic      [W-1:0] den_r
);

  logic [W:0]   shifted;
  logic [W:0]   diff;
  logic         ge;
  logic [W-1:0] rem_nxt;
  logic [W-1:0] nq_nxt;

  always_comb begin
    shifted = {rem, nq[W-1]};
    diff    = shifted - {1'b0, den};
    ge      = (shifted >= {1'b0, den});
    rem_nxt = ge ? diff[W-1:0] : shifted[W-1:0];
    nq_nxt  = {nq[W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r <= rem_nxt;
      nq_r  <= nq_nxt;
      den_r <= den;
    end
  end

endmodule : rd64_stage

`default_nettype wire

### src/rd64_post.sv
// Output stage: quotient sign fix, zero-divisor override, output register and skid.
`default_nettype none

module rd64_post
  import rd64_pkg::*;
#(
  parameter int W = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire rd_ctl_t      ctl,
  input  wire logic [W-1:0] quo,
  output logic              adv,
  output logic              out_vld_r,
  input  wire logic         out_rdy,
  output logic      [W-1:0] out_quo_r,
  output logic              out_dbz_r
);

  logic         skid_vld_r;
  logic         skid_vld_nxt;
  logic [W-1:0] skid_quo_r;
  logic         skid_dbz_r;
  logic         out_vld_nxt;
  logic [W-1:0] res;
  logic         out_load;
  logic         skid_load;
  logic         skid_drain;

  always_comb begin
    if (ctl.dbz) begin
      res = '0;
    end else if (ctl.flip) begin
      res = ~quo + W'(1);
    end else begin
      res = quo;
    end
  end

  // pipeline moves whenever the skid slot is free
  assign adv = !skid_vld_r;

  always_comb begin
    out_load     = 1'b0;
    skid_load    = 1'b0;
    skid_drain   = 1'b0;
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    if (skid_vld_r) begin
      if (out_rdy) begin
        skid_drain   = 1'b1;
        out_vld_nxt  = 1'b1;
        skid_vld_nxt = 1'b0;
      end
    end else if (out_vld_r && !out_rdy) begin
      if (ctl.vld) begin
        skid_load    = 1'b1;
        skid_vld_nxt = 1'b1;
      end
    end else begin
      out_load    = 1'b1;
      out_vld_nxt = ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_drain) begin
      out_quo_r <= skid_quo_r;
      out_dbz_r <= skid_dbz_r;
    end else if (out_load) begin
      out_quo_r <= res;
      out_dbz_r <= ctl.dbz;
    end
    if (skid_load) begin
      skid_quo_r <= res;
      skid_dbz_r <= ctl.dbz;
    end
  end

endmodule : rd64_post

`default_nettype wire

### src/restoring_divider_64_unit.sv
// Top level of the fully pipelined signed/unsigned restoring divider.
//
// Usage:
//   Input channel (in_*): one beat per division. in_tuser carries the kind
//   (0 unsigned, 1 signed), in_tdata the dividend and divisor. Only the low
//   DATA_WIDTH bits of each operand are used; in signed mode bit
//   DATA_WIDTH-1 is the sign.
//   Result channel (out_*): one beat per input beat, in order. out_tdata is
//   the quotient truncated toward zero, zero-extended to 64 bits; out_tuser
//   flags a zero divisor, in which case the quotient is zero. The most
//   negative dividend divided by minus one returns the same bit pattern.
//   Stages: one sign stage, one register per quotient bit, one output
//   register.
//   Throughput: one beat per cycle while the output is not stalled. Each
//   stage holds one trial subtract of DATA_WIDTH + 1 bits, which sets the clock.
//   Stall: a two-entry output (register plus skid) decouples the sides;
//   in_tready drops only once a result waits in both, and then the whole
//   pipeline freezes without losing or repeating a beat.
//   Reset: synchronous, active low; clears every valid bit, no data flush.
`default_nettype none

module restoring_divider_64_unit
  import rd64_pkg::*;
#(
  parameter int DATA_WIDTH = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // slave side
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [2*FIELD_W-1:0] in_tdata,   // [63:0] dividend, [127:64] divisor
  input  wire logic                 in_tuser,   // [0] kind
  // master side
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [FIELD_W-1:0]        out_tdata,  // [63:0] quotient
  output logic                      out_tuser   // [0] divide_by_zero
);

  localparam int W = DATA_WIDTH;

  logic    adv;
  logic    in_beat;

  // stage chain: index 0 is the sign stage output, index W the last quotient bit
  rd_ctl_t      ctl_a [W+1];
  logic [W-1:0] rem_a [W+1];
  logic [W-1:0] nq_a  [W+1];
  logic [W-1:0] den_a [W+1];

  logic [W-1:0] quo_r;

  assign in_tready = adv;
  assign in_beat   = in_tvalid && in_tready;

  rd64_prep #(.W(W)) u_prep (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .in_vld(in_beat),
    .kind  (in_tuser),
    .num   (in_tdata[W-1:0]),
    .den   (in_tdata[FIELD_W+W-1:FIELD_W]),
    .ctl_r (ctl_a[0]),
    .num_r (nq_a[0]),
    .den_r (den_a[0])
  );

  // partial remainder starts at zero
  assign rem_a[0] = '0;

  for (genvar i = 0; i < W; i++) begin : g_step
    rd64_stage #(.W(W)) u_stage (
      .clk  (clk),
      .rst_n(rst_n),
      .adv  (adv),
      .ctl  (ctl_a[i]),
      .rem  (rem_a[i]),
      .nq   (nq_a[i]),
      .den  (den_a[i]),
      .ctl_r(ctl_a[i+1]),
      .rem_r(rem_a[i+1]),
      .nq_r (nq_a[i+1]),
      .den_r(den_a[i+1])
    );
  end

  rd64_post #(.W(W)) u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl_a[W]),
    .quo      (nq_a[W]),
    .adv      (adv),
    .out_vld_r(out_tvalid),
    .out_rdy  (out_tready),
    .out_quo_r(quo_r),
    .out_dbz_r(out_tuser)
  );

  // upper quotient bits are zero when DATA_WIDTH < 64
  assign out_tdata = FIELD_W'(quo_r);

`ifndef SYNTHESIS
  // zero divisor always comes with a zero quotient
  a_dbz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("divide_by_zero beat with nonzero quotient");

  // input side stalls only while a result is waiting
  a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result pending");

  // a full skid drains in one taken beat
  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready && out_tready |=> in_tready)
    else $error("skid did not drain after output beat");
`endif

endmodule : restoring_divider_64_unit

`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench for restoring_divider_64_unit: directed table, then random divisions.
`timescale 1ns / 1ps

module tb;
  import rd64_pkg::*;

  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MOST_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MINUS_7  = 64'hFFFF_FFFF_FFFF_FFF9;
  localparam logic [63:0] MINUS_5  = 64'hFFFF_FFFF_FFFF_FFFB;
  localparam logic [63:0] MINUS_2  = 64'hFFFF_FFFF_FFFF_FFFE;
  localparam int NUM_ROWS    = 25;
  localparam int NUM_RANDOM  = 2000;
  localparam int QUIET_TAIL  = 300;   // last random beats run with no idling
  localparam int HOLD_AT     = 600;   // random beat that starts the long sink stall
  localparam int HOLD_CYCLES = 400;   // well past the pipeline depth
  localparam int DRAIN_WAIT  = 80;    // beyond the divider's pipeline depth

  typedef struct packed {
    logic [63:0] quo;
    logic        dbz;
  } quot_t;

  // one directed division; chk marks a hand-typed expected result
  typedef struct packed {
    logic        kind;
    logic [63:0] dividend;
    logic [63:0] divisor;
    logic        chk;
    logic [63:0] quo;
    logic        dbz;
  } div_row_t;

  logic          clk = 1'b0;
  logic          rst_n;
  logic          in_tvalid;
  logic          in_tready;
  logic [127:0]  in_tdata;   // [63:0] dividend, [127:64] divisor
  logic          in_tuser;   // [0] kind
  logic          out_tvalid;
  logic          out_tready;
  logic [63:0]   out_tdata;  // [63:0] quotient
  logic          out_tuser;  // [0] divide_by_zero

  quot_t quot_q[$];          // quotients still owed by the divider
  int    mismatch_cnt = 0;
  bit    src_idle_on  = 1'b1;
  bit    sink_idle_on = 1'b1;
  bit    hold_req     = 1'b0;

  div_row_t dir_rows [NUM_ROWS] = '{
    // zero divisor, both kinds
    '{KIND_UNSIGNED, 64'd0,    64'd0,    1'b1, 64'd0,    1'b1},
    '{KIND_SIGNED,   MOST_NEG, 64'd0,    1'b1, 64'd0,    1'b1},
    '{KIND_UNSIGNED, ALL_ONES, 64'd0,    1'b1, 64'd0,    1'b1},
    '{KIND_SIGNED,   ALL_ONES, 64'd0,    1'b1, 64'd0,    1'b1},
    // most negative over minus one wraps to itself
    '{KIND_SIGNED,   MOST_NEG, ALL_ONES, 1'b1, MOST_NEG, 1'b0},
    '{KIND_UNSIGNED, ALL_ONES, 64'd1,    1'b1, ALL_ONES, 1'b0},
    '{KIND_UNSIGNED, ALL_ONES, ALL_ONES, 1'b1, 64'd1,    1'b0},
    '{KIND_SIGNED,   ALL_ONES, ALL_ONES, 1'b1, 64'd1,    1'b0},
    '{KIND_UNSIGNED, 64'd0,    ALL_ONES, 1'b1, 64'd0,    1'b0},
    '{KIND_UNSIGNED, 64'd1,    ALL_ONES, 1'b1, 64'd0,    1'b0},
    // most negative divisor has magnitude 2^63
    '{KIND_SIGNED,   MOST_NEG, MOST_NEG, 1'b1, 64'd1,    1'b0},
    '{KIND_SIGNED,   MOST_NEG, 64'd1,    1'b1, MOST_NEG, 1'b0},
    '{KIND_SIGNED,   MOST_POS, MOST_NEG, 1'b1, 64'd0,    1'b0},
    '{KIND_UNSIGNED, MOST_NEG, MOST_NEG, 1'b1, 64'd1,    1'b0},
    '{KIND_UNSIGNED, MOST_POS, 64'd1,    1'b1, MOST_POS, 1'b0},
    '{KIND_SIGNED,   MOST_POS, MOST_POS, 1'b1, 64'd1,    1'b0},
    // truncation toward zero, all sign combinations
    '{KIND_SIGNED,   MOST_NEG, 64'd2,    1'b0, 64'd0,    1'b0},
    '{KIND_SIGNED,   MINUS_7,  64'd2,    1'b0, 64'd0,    1'b0},
    '{KIND_SIGNED,   64'd7,    MINUS_2,  1'b0, 64'd0,    1'b0},
    '{KIND_SIGNED,   MINUS_7,  MINUS_2,  1'b0, 64'd0,    1'b0},
    '{KIND_UNSIGNED, MINUS_7,  64'd2,    1'b0, 64'd0,    1'b0},
    '{KIND_UNSIGNED, 64'd100,  64'd7,    1'b1, 64'd14,   1'b0},
    '{KIND_SIGNED,   64'd0,    MINUS_5,  1'b1, 64'd0,    1'b0},
    '{KIND_SIGNED,   64'd1,    MOST_NEG, 1'b1, 64'd0,    1'b0},
    '{KIND_UNSIGNED, 64'd5,    64'd7,    1'b1, 64'd0,    1'b0}
  };

  restoring_divider_64_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #10 clk = ~clk;

  // Divide magnitudes, fix the sign afterwards; zero divisor forces zero.
  function automatic quot_t predict_quotient(logic kind, logic [63:0] num, logic [63:0] den);
    quot_t       r;
    logic [63:0] n;
    logic [63:0] d;
    logic        neg;
    n     = num;
    d     = den;
    neg   = 1'b0;
    r.dbz = (den == 64'd0);
    r.quo = 64'd0;
    if (!r.dbz) begin
      if (kind == KIND_SIGNED) begin
        if (n[63]) begin
          n   = ~n + 64'd1;
          neg = ~neg;
        end
        if (d[63]) begin
          d   = ~d + 64'd1;
          neg = ~neg;
        end
      end
      r.quo = n / d;
      if (neg) r.quo = ~r.quo + 64'd1;
    end
    return r;
  endfunction

  // Operands biased toward edges and short magnitudes so every quotient width shows up.
  function automatic logic [63:0] pick_operand();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 11))
      0:       v = 64'd0;
      1:       v = ALL_ONES;
      2:       v = MOST_NEG;
      3:       v = MOST_POS;
      4:       v = 64'($urandom_range(1, 15));
      5, 6:    v = v >> $urandom_range(0, 63);
      7:       v = ~(v >> $urandom_range(0, 63)) + 64'd1;  // small negative
      default: ;
    endcase
    return v;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t ns: %s got %h want %h", $time, what, got, want);
    mismatch_cnt++;
  endtask

  // Offer one division on the input side and hold it until accepted; the
  // expected quotient is queued on the accepting edge.
  task automatic push_division(logic kind, logic [63:0] num, logic [63:0] den,
                               bit chk, quot_t typed);
    int gap;
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {den, num};
    do @(posedge clk); while (!(in_tvalid && in_tready));
    quot_q.push_back(chk ? typed : predict_quotient(kind, num, den));
  endtask

  // Result side: each accepted beat is matched against the oldest quotient owed.
  always @(posedge clk) begin
    quot_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (quot_q.size() == 0) begin
        report_mismatch("unexpected result beat, quotient", out_tdata, 64'd0);
      end else begin
        want = quot_q.pop_front();
        if (out_tdata !== want.quo) report_mismatch("quotient", out_tdata, want.quo);
        if (out_tuser !== want.dbz)
          report_mismatch("divide_by_zero", {63'd0, out_tuser}, {63'd0, want.dbz});
      end
    end
  end

  // Sink readiness: random stall bursts, ready stretches, and one long hold
  // on request so the pipeline and skid fill and in_tready drops.
  initial begin
    int hold_len;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        hold_req   = 1'b0;
        hold_len   = HOLD_CYCLES;
      end else if (sink_idle_on && $urandom_range(0, 6) == 0) begin
        out_tready <= 1'b0;
        hold_len   = $urandom_range(1, 19);
      end else begin
        out_tready <= 1'b1;
        hold_len   = $urandom_range(1, 30);
      end
      repeat (hold_len - 1) @(negedge clk);
    end
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("restoring_divider_64_unit regression: fail");
    $finish;
  end

  initial begin
    quot_t       typed;
    logic [63:0] num;
    logic [63:0] den;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = KIND_UNSIGNED;
    out_tready = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_ROWS; i++) begin
      typed.quo = dir_rows[i].quo;
      typed.dbz = dir_rows[i].dbz;
      push_division(dir_rows[i].kind, dir_rows[i].dividend, dir_rows[i].divisor,
                    dir_rows[i].chk, typed);
    end

    typed = '0;
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == HOLD_AT) hold_req = 1'b1;
      if (i == NUM_RANDOM - QUIET_TAIL) begin
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
      end
      num = pick_operand();
      den = pick_operand();
      push_division(1'($urandom_range(0, 1)), num, den, 1'b0, typed);
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (quot_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_cnt == 0 && quot_q.size() == 0) begin
      $display("restoring_divider_64_unit regression: pass");
    end else begin
      $display("restoring_divider_64_unit regression: fail");
    end
    $finish;
  end

endmodule
